// ----- hdl/url_percent_decoder_macros.svh -----
// Assertion macros shared by the URL percent decoder modules.
`ifndef URL_PERCENT_DECODER_MACROS_SVH
`define URL_PERCENT_DECODER_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define UPD_ASSERT_NOW(lbl, ck, rn, cond, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (cond)) else $error(msg);

// Check a consequence in the cycle after its trigger.
`define UPD_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

// Check a consequence in the same cycle as its trigger.
`define UPD_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

`endif

// ----- hdl/upd_pkg.sv -----
// Package: character codes, queue depth, decoder phase, run type and hex helpers.
`timescale 1ns / 1ps

package upd_pkg;

    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_LOWER_A = 8'h61;

    // Run queue depth and pointer width
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } phase_t;

    // Decoded bytes caused by one input item, in emission order
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] cnt;
        logic       fin;
    } run_t;

    function automatic logic is_hex(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) ||
               ((c >= 8'h41) && (c <= 8'h46)) ||
               ((c >= CH_LOWER_A) && (c <= 8'h66));
    endfunction

    // Letters have low nibble 1..6 for A..F, so add nine
    function automatic logic [3:0] hex_val(input logic [7:0] c);
        return (c <= 8'h39) ? c[3:0] : (c[3:0] + 4'd9);
    endfunction

endpackage

// ----- hdl/upd_enc_if.sv -----
// Interface: encoded input channel.
`timescale 1ns / 1ps

interface upd_enc_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_final;

    modport source (output valid, output in_byte, output in_final, input ready);
    modport sink   (input valid, input in_byte, input in_final, output ready);
endinterface

// ----- hdl/upd_dec_if.sv -----
// Interface: decoded output channel.
`timescale 1ns / 1ps

interface upd_dec_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       stream_end;

    modport source (output valid, output out_byte, output run_last, output stream_end,
                    input ready);
    modport sink   (input valid, input out_byte, input run_last, input stream_end,
                    output ready);
endinterface

// ----- hdl/upd_front.sv -----
// Front end: accepts encoded bytes, tracks escape phase, builds decoded runs.
`timescale 1ns / 1ps
`include "url_percent_decoder_macros.svh"

module upd_front
(
    input  logic          clk,
    input  logic          rst_n,
    upd_enc_if.sink       enc,
    input  logic          push_ready,
    output logic          push_valid,
    output upd_pkg::run_t push_run
);

    upd_pkg::phase_t phase_reg;
    upd_pkg::phase_t phase_next;
    logic [7:0]      held_reg;
    logic [7:0]      held_next;

    logic       accept;
    logic [7:0] c;
    logic       fin;
    logic       c_hex;
    logic       p_emit;
    logic [7:0] p_byte;
    logic       p_pct;

    assign enc.ready = push_ready;
    assign accept    = enc.valid && enc.ready;
    assign c         = enc.in_byte;
    assign fin       = enc.in_final;
    assign c_hex     = upd_pkg::is_hex(c);

    // Classify the new byte as ordinary input
    always_comb
    begin
        p_emit = 1'b1;
        p_byte = c;
        p_pct  = 1'b0;
        if (c == upd_pkg::CH_PLUS)
        begin
            p_byte = upd_pkg::CH_SPACE;
        end
        else if ((c == upd_pkg::CH_PERCENT) && !fin)
        begin
            p_emit = 1'b0;
            p_pct  = 1'b1;
        end
    end

    // Next phase and held digit
    always_comb
    begin
        phase_next = phase_reg;
        held_next  = held_reg;
        if (accept)
        begin
            case (phase_reg)
                upd_pkg::PH_PCT:
                begin
                    if (c_hex && !fin)
                    begin
                        phase_next = upd_pkg::PH_DIGIT;
                        held_next  = c;
                    end
                    else
                    begin
                        phase_next = p_pct ? upd_pkg::PH_PCT : upd_pkg::PH_IDLE;
                    end
                end
                upd_pkg::PH_DIGIT:
                begin
                    held_next = 8'h00;
                    if (c_hex)
                    begin
                        phase_next = upd_pkg::PH_IDLE;
                    end
                    else
                    begin
                        phase_next = p_pct ? upd_pkg::PH_PCT : upd_pkg::PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = p_pct ? upd_pkg::PH_PCT : upd_pkg::PH_IDLE;
                end
            endcase
            // Final byte always leaves the decoder idle
            if (fin)
            begin
                phase_next = upd_pkg::PH_IDLE;
                held_next  = 8'h00;
            end
        end
    end

    // Build the run of decoded bytes for this item
    always_comb
    begin
        push_run.b0  = p_byte;
        push_run.b1  = 8'h00;
        push_run.b2  = 8'h00;
        push_run.cnt = p_emit ? 2'd1 : 2'd0;
        push_run.fin = fin;
        case (phase_reg)
            upd_pkg::PH_PCT:
            begin
                if (c_hex && !fin)
                begin
                    push_run.cnt = 2'd0;
                end
                else
                begin
                    push_run.b0  = upd_pkg::CH_PERCENT;
                    push_run.b1  = p_byte;
                    push_run.cnt = p_emit ? 2'd2 : 2'd1;
                end
            end
            upd_pkg::PH_DIGIT:
            begin
                if (c_hex)
                begin
                    // High nibble times sixteen plus low nibble
                    push_run.b0  = {upd_pkg::hex_val(held_reg), upd_pkg::hex_val(c)};
                    push_run.cnt = 2'd1;
                end
                else
                begin
                    push_run.b0  = upd_pkg::CH_PERCENT;
                    push_run.b1  = held_reg;
                    push_run.b2  = p_byte;
                    push_run.cnt = p_emit ? 2'd3 : 2'd2;
                end
            end
            default:
            begin
                push_run.cnt = p_emit ? 2'd1 : 2'd0;
            end
        endcase
    end

    assign push_valid = accept && (push_run.cnt != 2'd0);

    // Phase and held digit registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= upd_pkg::PH_IDLE;
            held_reg  <= 8'h00;
        end
        else
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

    `UPD_ASSERT_NEXT(a_fin_to_idle, clk, rst_n, accept && fin, phase_reg == upd_pkg::PH_IDLE, "final item left decoder busy")
    `UPD_ASSERT_SAME(a_push_has_room, clk, rst_n, push_valid, push_ready, "run pushed into full queue")

endmodule

// ----- hdl/upd_queue.sv -----
// Run queue: short FIFO of decoded runs between front and back ends.
`timescale 1ns / 1ps
`include "url_percent_decoder_macros.svh"

module upd_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    input  upd_pkg::run_t push_run,
    output logic          push_ready,
    output logic          head_valid,
    output upd_pkg::run_t head_run,
    input  logic          pop
);

    upd_pkg::run_t                mem_reg [upd_pkg::QDEPTH];
    logic [upd_pkg::QAW-1:0]      wr_ptr_reg;
    logic [upd_pkg::QAW-1:0]      wr_ptr_next;
    logic [upd_pkg::QAW-1:0]      rd_ptr_reg;
    logic [upd_pkg::QAW-1:0]      rd_ptr_next;
    logic [upd_pkg::QAW:0]        cnt_reg;
    logic [upd_pkg::QAW:0]        cnt_next;
    logic                         do_push;
    logic                         do_pop;

    assign push_ready = (cnt_reg != (upd_pkg::QAW+1)'(upd_pkg::QDEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_run   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store runs
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_run;
        end
    end

    `UPD_ASSERT_NOW(a_cnt_bound, clk, rst_n, cnt_reg <= (upd_pkg::QAW+1)'(upd_pkg::QDEPTH), "queue count overflow")
    `UPD_ASSERT_SAME(a_pop_nonempty, clk, rst_n, pop, head_valid, "pop from empty queue")

endmodule

// ----- hdl/upd_back.sv -----
// Back end: splits the head run into bytes and drives the output register.
`timescale 1ns / 1ps
`include "url_percent_decoder_macros.svh"

module upd_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    input  upd_pkg::run_t head_run,
    output logic          pop,
    upd_dec_if.source     dec
);

    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_byte_reg;
    logic       run_last_reg;
    logic       stream_end_reg;

    logic       load;
    logic       last;
    logic [7:0] sel_byte;

    // Pick the byte at the current position of the head run
    always_comb
    begin
        case (idx_reg)
            2'd0:    sel_byte = head_run.b0;
            2'd1:    sel_byte = head_run.b1;
            default: sel_byte = head_run.b2;
        endcase
    end

    assign last = (idx_reg == (head_run.cnt - 2'd1));
    assign load = head_valid && (!out_valid_reg || dec.ready);
    assign pop  = load && last;

    // Advance within the run, hold while the output stalls
    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !dec.ready;
        if (load)
        begin
            idx_next       = last ? 2'd0 : idx_reg + 2'd1;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg   <= sel_byte;
            run_last_reg   <= last;
            stream_end_reg <= last && head_run.fin;
        end
    end

    assign dec.valid      = out_valid_reg;
    assign dec.out_byte   = out_byte_reg;
    assign dec.run_last   = run_last_reg;
    assign dec.stream_end = stream_end_reg;

    `UPD_ASSERT_NOW(a_idx_in_run, clk, rst_n, (idx_reg == 2'd0) || (head_valid && (idx_reg < head_run.cnt)), "position outside head run")

endmodule

// ----- hdl/url_percent_decoder.sv -----
// Top level: streaming URL percent decoder (form-urlencoded).
//
//  channel | role   | payload                          | handshake
//  --------+--------+----------------------------------+-------------
//  enc     | sink   | in_byte[7:0], in_final           | valid/ready
//  dec     | source | out_byte[7:0], run_last, stream_end | valid/ready
//
// One item is accepted per cycle while the run queue has room; it yields a
// run of 0 to 3 decoded bytes. Output bytes leave one per cycle while
// dec.ready is high, from a registered output stage; a run goes into the run
// queue first and its bytes then pass through the output register. The
// four-entry run queue absorbs three-byte runs; when it fills, enc.ready
// drops until the output drains. Reset is asynchronous and needs no sweep.
`timescale 1ns / 1ps

module url_percent_decoder
(
    input  logic      clk,
    input  logic      rst_n,
    upd_enc_if.sink   enc,
    upd_dec_if.source dec
);

    logic          push_valid;
    logic          push_ready;
    upd_pkg::run_t push_run;
    logic          head_valid;
    upd_pkg::run_t head_run;
    logic          pop;

    upd_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .enc        (enc),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_run   (push_run)
    );

    upd_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_run   (push_run),
        .push_ready (push_ready),
        .head_valid (head_valid),
        .head_run   (head_run),
        .pop        (pop)
    );

    upd_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_run   (head_run),
        .pop        (pop),
        .dec        (dec)
    );

endmodule

// ----- tb/tb_top.sv -----
// Testbench for url_percent_decoder: directed and random encoded strings against a local decoder.
`timescale 1ns / 1ps

module tb_top;

    // ASCII bounds of the hex digit ranges
    localparam logic [7:0] DIGIT_0 = 8'h30;
    localparam logic [7:0] DIGIT_9 = 8'h39;
    localparam logic [7:0] UPPER_A = 8'h41;
    localparam logic [7:0] UPPER_F = 8'h46;
    localparam logic [7:0] LOWER_F = 8'h66;

    localparam int ROUND_ITEMS = 115;
    localparam int SETTLE_CYCLES = 16;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       term;
    } dec_result_t;

    logic clk = 1'b0;
    logic rst_n;

    upd_enc_if enc ();
    upd_dec_if dec ();

    url_percent_decoder uut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .enc   (enc),
        .dec   (dec)
    );

    // Decoder state mirrored by the testbench
    upd_pkg::phase_t dec_phase = upd_pkg::PH_IDLE;
    logic [7:0]      held_hex  = 8'h00;
    logic [7:0]      run_bytes[$];
    dec_result_t     expected_bytes[$];

    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int mismatch_count = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic is_hex_char(input logic [7:0] c);
        return ((c >= DIGIT_0) && (c <= DIGIT_9)) ||
               ((c >= UPPER_A) && (c <= UPPER_F)) ||
               ((c >= upd_pkg::CH_LOWER_A) && (c <= LOWER_F));
    endfunction

    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [7:0] v;
        if (c <= DIGIT_9)
            v = c - DIGIT_0;
        else if (c <= UPPER_F)
            v = c - UPPER_A + 8'd10;
        else
            v = c - upd_pkg::CH_LOWER_A + 8'd10;
        return v[3:0];
    endfunction

    function automatic logic [7:0] rand_hex_char();
        case ($urandom_range(2))
            0: return 8'(DIGIT_0 + $urandom_range(9));
            1: return 8'(UPPER_A + $urandom_range(5));
            default: return 8'(upd_pkg::CH_LOWER_A + $urandom_range(5));
        endcase
    endfunction

    function automatic logic [7:0] rand_non_hex_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(255));
        while (is_hex_char(c));
        return c;
    endfunction

    // Handle one byte as if nothing were held
    function automatic void decode_plain(input logic [7:0] c, input logic fin);
        if (c == upd_pkg::CH_PLUS)
            run_bytes.push_back(upd_pkg::CH_SPACE);
        else if ((c == upd_pkg::CH_PERCENT) && !fin)
            dec_phase = upd_pkg::PH_PCT;
        else
            run_bytes.push_back(c);
    endfunction

    // Advance the mirrored decoder by one item and queue the bytes it yields
    function automatic void predict_decode(input logic [7:0] c, input logic fin);
        upd_pkg::phase_t ph;
        dec_result_t     r;
        ph = dec_phase;
        run_bytes.delete();
        dec_phase = upd_pkg::PH_IDLE;
        case (ph)
            upd_pkg::PH_PCT:
            begin
                if (is_hex_char(c) && !fin)
                begin
                    held_hex  = c;
                    dec_phase = upd_pkg::PH_DIGIT;
                end
                else
                begin
                    run_bytes.push_back(upd_pkg::CH_PERCENT);
                    decode_plain(c, fin);
                end
            end
            upd_pkg::PH_DIGIT:
            begin
                if (is_hex_char(c))
                    run_bytes.push_back({nibble_of(held_hex), nibble_of(c)});
                else
                begin
                    // Broken escape: release the percent, replay the digit and the byte
                    run_bytes.push_back(upd_pkg::CH_PERCENT);
                    decode_plain(held_hex, 1'b0);
                    decode_plain(c, fin);
                end
                held_hex = 8'h00;
            end
            default:
                decode_plain(c, fin);
        endcase
        if (fin)
        begin
            dec_phase = upd_pkg::PH_IDLE;
            held_hex  = 8'h00;
        end
        foreach (run_bytes[k])
        begin
            r.data = run_bytes[k];
            r.last = (k == run_bytes.size() - 1);
            r.term = r.last && fin;
            expected_bytes.push_back(r);
        end
    endfunction

    // Present one item, hold it until accepted
    task automatic send_item(input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < src_idle_pct)
        begin
            enc.valid <= 1'b0;
            @(posedge clk);
        end
        predict_decode(b, fin);
        enc.valid    <= 1'b1;
        enc.in_byte  <= b;
        enc.in_final <= fin;
        @(posedge clk);
        while (!enc.ready)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        enc.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_bytes.size() != 0);
    endtask

    task automatic test_plain_bytes();
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(upd_pkg::CH_PLUS, 1'b1);
    endtask

    task automatic test_escapes();
        // NUL, mixed case, and an escape closed by the final byte
        send_item(upd_pkg::CH_PERCENT, 1'b0);
        send_item("0", 1'b0);
        send_item("0", 1'b0);
        send_item(upd_pkg::CH_PERCENT, 1'b0);
        send_item("f", 1'b0);
        send_item("F", 1'b0);
        send_item(upd_pkg::CH_PERCENT, 1'b0);
        send_item("7", 1'b0);
        send_item("e", 1'b1);
    endtask

    task automatic test_broken_escapes();
        // Percent then non-hex
        send_item(upd_pkg::CH_PERCENT, 1'b0);
        send_item("G", 1'b0);
        // Percent, digit, plus: three bytes from one item
        send_item(upd_pkg::CH_PERCENT, 1'b0);
        send_item("4", 1'b0);
        send_item(upd_pkg::CH_PLUS, 1'b0);
        // Broken escape whose last byte opens a fresh one
        send_item(upd_pkg::CH_PERCENT, 1'b0);
        send_item("A", 1'b0);
        send_item(upd_pkg::CH_PERCENT, 1'b0);
        send_item("4", 1'b0);
        send_item("1", 1'b1);
        // Pending escapes flushed by the final byte
        send_item(upd_pkg::CH_PERCENT, 1'b1);
        send_item(upd_pkg::CH_PERCENT, 1'b0);
        send_item("b", 1'b1);
        send_item(upd_pkg::CH_PERCENT, 1'b0);
        send_item(upd_pkg::CH_PERCENT, 1'b1);
    endtask

    // Mostly well-formed strings with random content, plus broken escapes and noise
    task automatic test_random_streams(input int n_items);
        logic [7:0] text[$];
        int         sent;
        int         tokens;
        int         pick;
        sent = 0;
        while (sent < n_items)
        begin
            text.delete();
            tokens = $urandom_range(1, 8);
            repeat (tokens)
            begin
                pick = $urandom_range(99);
                if (pick < 40)
                    text.push_back(8'($urandom_range(255)) == upd_pkg::CH_PERCENT ?
                                   upd_pkg::CH_PLUS : 8'($urandom_range(255)));
                else if (pick < 50)
                    text.push_back(upd_pkg::CH_PLUS);
                else if (pick < 75)
                begin
                    text.push_back(upd_pkg::CH_PERCENT);
                    text.push_back(rand_hex_char());
                    text.push_back(rand_hex_char());
                end
                else if (pick < 80)
                begin
                    text.push_back(upd_pkg::CH_PERCENT);
                    text.push_back(rand_non_hex_char());
                end
                else if (pick < 85)
                begin
                    text.push_back(upd_pkg::CH_PERCENT);
                    text.push_back(rand_hex_char());
                    text.push_back(rand_non_hex_char());
                end
                else
                    text.push_back(8'($urandom_range(255)));
            end
            foreach (text[i])
                send_item(text[i], i == text.size() - 1);
            sent += text.size();
        end
    endtask

    // Check each decoded byte against the oldest expectation; randomize sink stalls
    initial
    begin
        dec_result_t want;
        dec.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && dec.valid && dec.ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $error("unexpected result: out_byte %h", dec.out_byte);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (dec.out_byte !== want.data)
                    begin
                        $error("out_byte: expected %h, got %h", want.data, dec.out_byte);
                        mismatch_count++;
                    end
                    if (dec.run_last !== want.last)
                    begin
                        $error("run_last: expected %b, got %b", want.last, dec.run_last);
                        mismatch_count++;
                    end
                    if (dec.stream_end !== want.term)
                    begin
                        $error("stream_end: expected %b, got %b", want.term, dec.stream_end);
                        mismatch_count++;
                    end
                end
            end
            dec.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    initial
    begin
        enc.valid    <= 1'b0;
        enc.in_byte  <= 8'h00;
        enc.in_final <= 1'b0;
        rst_n        <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_pct = 16;
        snk_idle_pct = 77;
        test_plain_bytes();
        test_escapes();
        test_broken_escapes();
        test_random_streams(ROUND_ITEMS);
        wait_drained();

        src_idle_pct = 77;
        snk_idle_pct = 16;
        test_random_streams(ROUND_ITEMS);
        wait_drained();

        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_random_streams(ROUND_ITEMS);
        wait_drained();

        // Catch any stray output after the last expected byte
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_bytes.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Abort a hung run
    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
